// ===== design/window_rank_mean_filter_macros.svh =====
// assertion macros for the window rank / mean filter checker
// used by wrmf_checker, no other dependencies
`ifndef WINDOW_RANK_MEAN_FILTER_MACROS_SVH
`define WINDOW_RANK_MEAN_FILTER_MACROS_SVH

// check masked while reset is active
`define WRMF_CHECK(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check that also holds across reset
`define WRMF_CHECK_ALWAYS(name, clk, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/wrmf_pkg.sv =====
// shared types, constants and helpers of the window rank / mean filter
// no dependencies
`default_nettype none

package wrmf_pkg;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;
    localparam int DEF_MAX_WINDOW = 11;

    localparam int DIM_W    = 11;
    localparam int WSIZE_W  = 4;
    localparam int MODE_W   = 2;
    localparam int PLANE_W  = 2;
    localparam int PIX_W    = 8;
    localparam int ITEMS_W  = 21;
    localparam int P_W      = 3;
    localparam int APB_AW   = 5;
    localparam int APB_DW   = 32;
    localparam int REGI_W   = 3;

    localparam logic [REGI_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
    localparam logic [REGI_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
    localparam logic [REGI_W-1:0] REG_WINDOW_SIZE  = 3'd2;
    localparam logic [REGI_W-1:0] REG_FILTER_MODE  = 3'd3;
    localparam logic [REGI_W-1:0] REG_PLANE_SELECT = 3'd4;

    localparam logic [MODE_W-1:0] MODE_MEDIAN = 2'd0;
    localparam logic [MODE_W-1:0] MODE_MAX    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_MIN    = 2'd2;
    localparam logic [MODE_W-1:0] MODE_MEAN   = 2'd3;

    localparam logic [PLANE_W-1:0] PLANE_B = 2'd2;
    localparam logic [PLANE_W-1:0] PLANE_C = 2'd3;

    localparam logic ACT_PIXEL = 1'b0;

    localparam logic [DIM_W-1:0]   RST_IMAGE_WIDTH  = 11'd256;
    localparam logic [DIM_W-1:0]   RST_IMAGE_HEIGHT = 11'd256;
    localparam logic [WSIZE_W-1:0] RST_WINDOW_SIZE  = 4'd3;

    typedef struct packed {
        logic             action;
        logic [PIX_W-1:0] chan_a;
        logic [PIX_W-1:0] chan_b;
        logic [PIX_W-1:0] chan_c;
    } t_in_item;

    typedef struct packed {
        logic [PIX_W-1:0] filtered;
        logic             frame_end;
    } t_out_item;

    typedef struct packed {
        logic [DIM_W-1:0]   image_width;
        logic [DIM_W-1:0]   image_height;
        logic [WSIZE_W-1:0] window_size;
        logic [MODE_W-1:0]  filter_mode;
        logic [PLANE_W-1:0] plane_select;
        logic               wr;
    } t_cfg;

    function automatic logic [P_W-1:0] half_window(input logic [WSIZE_W-1:0] wsize,
                                                   input int pmax);
        logic [P_W-1:0] p;
        case (wsize)
            4'd3:    p = 3'd1;
            4'd5:    p = 3'd2;
            4'd7:    p = 3'd3;
            4'd9:    p = 3'd4;
            default: p = 3'd5;
        endcase
        if (int'(p) > pmax) p = P_W'(pmax);
        return p;
    endfunction

endpackage

`default_nettype wire

// ===== design/wrmf_stream_if.sv =====
// valid / ready channel carrying one payload per transaction
// payload type given by parameter, no other dependencies
`default_nettype none

interface wrmf_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== design/wrmf_ram.sv =====
// simple dual port ram, one write and one registered read port
// no dependencies
`default_nettype none

module wrmf_ram #(
    parameter int DEPTH = 16,
    parameter int DW    = 8
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [DW-1:0]            i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [DW-1:0]            o_rdata
);
    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

`default_nettype wire

// ===== design/wrmf_apb_regs.sv =====
// apb configuration registers of the window rank / mean filter
// depends on wrmf_pkg
`default_nettype none

module wrmf_apb_regs (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [wrmf_pkg::APB_AW-1:0]    paddr,
    input  wire logic [wrmf_pkg::APB_DW-1:0]    pwdata,
    output logic      [wrmf_pkg::APB_DW-1:0]    prdata,
    output logic                                pready,
    output wrmf_pkg::t_cfg                      o_cfg
);
    logic [wrmf_pkg::DIM_W-1:0]   r_width;
    logic [wrmf_pkg::DIM_W-1:0]   r_height;
    logic [wrmf_pkg::WSIZE_W-1:0] r_wsize;
    logic [wrmf_pkg::MODE_W-1:0]  r_mode;
    logic [wrmf_pkg::PLANE_W-1:0] r_plane;
    logic [wrmf_pkg::REGI_W-1:0]  idx;
    logic                         wr_any;
    logic                         wr_hit;

    assign idx    = paddr[wrmf_pkg::APB_AW-1:2];
    assign wr_any = psel && penable && pwrite;
    assign pready = 1'b1;

    always_comb begin
        wr_hit = 1'b0;
        prdata = '0;
        unique case (idx)
            wrmf_pkg::REG_IMAGE_WIDTH: begin
                wr_hit = wr_any;
                prdata = wrmf_pkg::APB_DW'(r_width);
            end
            wrmf_pkg::REG_IMAGE_HEIGHT: begin
                wr_hit = wr_any;
                prdata = wrmf_pkg::APB_DW'(r_height);
            end
            wrmf_pkg::REG_WINDOW_SIZE: begin
                wr_hit = wr_any;
                prdata = wrmf_pkg::APB_DW'(r_wsize);
            end
            wrmf_pkg::REG_FILTER_MODE: begin
                wr_hit = wr_any;
                prdata = wrmf_pkg::APB_DW'(r_mode);
            end
            wrmf_pkg::REG_PLANE_SELECT: begin
                wr_hit = wr_any;
                prdata = wrmf_pkg::APB_DW'(r_plane);
            end
            default: begin
                wr_hit = 1'b0;
                prdata = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= wrmf_pkg::RST_IMAGE_WIDTH;
            r_height <= wrmf_pkg::RST_IMAGE_HEIGHT;
            r_wsize  <= wrmf_pkg::RST_WINDOW_SIZE;
            r_mode   <= wrmf_pkg::MODE_MEDIAN;
            r_plane  <= '0;
        end else if (wr_any) begin
            unique case (idx)
                wrmf_pkg::REG_IMAGE_WIDTH:  r_width  <= pwdata[wrmf_pkg::DIM_W-1:0];
                wrmf_pkg::REG_IMAGE_HEIGHT: r_height <= pwdata[wrmf_pkg::DIM_W-1:0];
                wrmf_pkg::REG_WINDOW_SIZE:  r_wsize  <= pwdata[wrmf_pkg::WSIZE_W-1:0];
                wrmf_pkg::REG_FILTER_MODE:  r_mode   <= pwdata[wrmf_pkg::MODE_W-1:0];
                wrmf_pkg::REG_PLANE_SELECT: r_plane  <= pwdata[wrmf_pkg::PLANE_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg.image_width  = r_width;
    assign o_cfg.image_height = r_height;
    assign o_cfg.window_size  = r_wsize;
    assign o_cfg.filter_mode  = r_mode;
    assign o_cfg.plane_select = r_plane;
    assign o_cfg.wr           = wr_hit;
endmodule

`default_nettype wire

// ===== design/wrmf_engine.sv =====
// frame tracking, line store, window gather and shared select / divide unit
// depends on wrmf_pkg, wrmf_stream_if, wrmf_ram
`default_nettype none

module wrmf_engine #(
    parameter int MAX_WIDTH  = wrmf_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = wrmf_pkg::DEF_MAX_HEIGHT,
    parameter int MAX_WINDOW = wrmf_pkg::DEF_MAX_WINDOW
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wrmf_pkg::t_cfg i_cfg,
    wrmf_stream_if.sink    i_pix,
    wrmf_stream_if.source  o_res
);
    localparam int DEPTH  = MAX_WINDOW * MAX_WIDTH;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CW     = $clog2(MAX_WIDTH);
    localparam int EW     = $clog2(MAX_WIDTH + 1);
    localparam int RW     = $clog2(MAX_HEIGHT);
    localparam int EH     = $clog2(MAX_HEIGHT + 1);
    localparam int TOT_W  = EW + EH;
    localparam int LAG_W  = EW + wrmf_pkg::P_W;
    localparam int PMAX   = (MAX_WINDOW - 1) / 2;
    localparam int DC_W   = $clog2(MAX_WINDOW);
    localparam int NWIN   = MAX_WINDOW * MAX_WINDOW;
    localparam int NCNT_W = $clog2(NWIN + 1);
    localparam int BUF_AW = $clog2(NWIN);
    localparam int SUM_W  = wrmf_pkg::PIX_W + NCNT_W;
    localparam int SR_W   = RW + 2;
    localparam int SC_W   = CW + 2;
    localparam int PW     = wrmf_pkg::PIX_W;

    typedef enum logic [2:0] {
        S_IDLE, S_BACK, S_LOAD, S_LOAD_END, S_PASS, S_PASS_END, S_DIV, S_DONE
    } t_state;

    t_state                  r_state;
    logic                    r_dirty;
    logic [EW-1:0]           r_w;
    logic [EH-1:0]           r_h;
    logic [wrmf_pkg::P_W-1:0] r_p;
    logic [TOT_W-1:0]        r_total;
    logic [LAG_W-1:0]        r_lag;
    logic [wrmf_pkg::ITEMS_W-1:0] r_items;
    logic [RW-1:0]           r_out_row;
    logic [CW-1:0]           r_out_col;
    logic [ADDR_W-1:0]       r_wr_ptr;
    logic [ADDR_W-1:0]       r_row_base;
    logic [ADDR_W-1:0]       r_rbase;
    logic [wrmf_pkg::P_W-1:0] r_back;
    logic [DC_W-1:0]         r_dr;
    logic [DC_W-1:0]         r_dc;
    logic signed [SR_W-1:0]  r_er;
    logic                    r_rd_vld;
    logic [NCNT_W-1:0]       r_wcnt;
    logic [PW-1:0]           r_min;
    logic [PW-1:0]           r_max;
    logic [SUM_W-1:0]        r_sum;
    logic [2:0]              r_bit;
    logic [PW-1:0]           r_prefix;
    logic [NCNT_W-1:0]       r_target;
    logic [NCNT_W-1:0]       r_cnt;
    logic [NCNT_W-1:0]       r_ridx;
    logic [SUM_W-1:0]        r_rem;
    logic [PW-1:0]           r_quo;
    logic [PW-1:0]           r_res;
    logic                    r_last;
    logic                    r_out_vld;
    wrmf_pkg::t_out_item     r_out;

    logic [EW-1:0]           n_w;
    logic [EH-1:0]           n_h;
    logic [wrmf_pkg::P_W-1:0] n_p;
    logic                    accept;
    logic                    in_frame;
    logic                    is_pix;
    logic [PW-1:0]           sample;
    logic [ADDR_W-1:0]       rb_add;
    logic [ADDR_W-1:0]       rb_sub;
    logic [ADDR_W-1:0]       base_add;
    logic [ADDR_W:0]         tmp_add;
    logic [ADDR_W:0]         tmp_base;
    logic [ADDR_W:0]         tmp_rd;
    logic signed [SC_W-1:0]  ec;
    logic signed [SC_W-1:0]  w_last;
    logic signed [SR_W-1:0]  h_last;
    logic [CW-1:0]           cc;
    logic [ADDR_W-1:0]       ls_raddr;
    logic [PW-1:0]           ls_rdata;
    logic [PW-1:0]           wb_rdata;
    logic                    ls_we;
    logic                    wb_we;
    logic [DC_W-1:0]         two_p;
    logic                    pass_hit;
    logic [NCNT_W-1:0]       cnt_now;
    logic [SUM_W:0]          div_sh;
    logic                    out_free;

    always_comb begin
        if (i_cfg.image_width == '0) begin
            n_w = EW'(1);
        end else if (32'(i_cfg.image_width) > 32'(MAX_WIDTH)) begin
            n_w = EW'(MAX_WIDTH);
        end else begin
            n_w = EW'(i_cfg.image_width);
        end
        if (i_cfg.image_height == '0) begin
            n_h = EH'(1);
        end else if (32'(i_cfg.image_height) > 32'(MAX_HEIGHT)) begin
            n_h = EH'(MAX_HEIGHT);
        end else begin
            n_h = EH'(i_cfg.image_height);
        end
        n_p = wrmf_pkg::half_window(i_cfg.window_size, PMAX);
    end

    assign i_pix.ready = (r_state == S_IDLE) && !r_dirty;
    assign accept      = i_pix.valid && i_pix.ready;
    assign in_frame    = 32'(r_items) < 32'(r_total);
    assign is_pix      = i_pix.payload.action == wrmf_pkg::ACT_PIXEL;
    assign ls_we       = accept && in_frame && is_pix;

    always_comb begin
        case (i_cfg.plane_select)
            wrmf_pkg::PLANE_B: sample = i_pix.payload.chan_b;
            wrmf_pkg::PLANE_C: sample = i_pix.payload.chan_c;
            default:           sample = i_pix.payload.chan_a;
        endcase
    end

    // modular row-base stepping
    always_comb begin
        tmp_add = (ADDR_W+1)'(r_rbase) + (ADDR_W+1)'(r_w);
        if (tmp_add >= (ADDR_W+1)'(DEPTH)) begin
            tmp_add = tmp_add - (ADDR_W+1)'(DEPTH);
        end
        rb_add = tmp_add[ADDR_W-1:0];
        if (r_rbase >= ADDR_W'(r_w)) begin
            rb_sub = r_rbase - ADDR_W'(r_w);
        end else begin
            rb_sub = ADDR_W'((ADDR_W+1)'(r_rbase) + (ADDR_W+1)'(DEPTH) - (ADDR_W+1)'(r_w));
        end
        tmp_base = (ADDR_W+1)'(r_row_base) + (ADDR_W+1)'(r_w);
        if (tmp_base >= (ADDR_W+1)'(DEPTH)) begin
            tmp_base = tmp_base - (ADDR_W+1)'(DEPTH);
        end
        base_add = tmp_base[ADDR_W-1:0];
    end

    // window column with edge replication
    always_comb begin
        w_last = $signed(SC_W'(r_w) - SC_W'(1));
        h_last = $signed(SR_W'(r_h) - SR_W'(1));
        ec = $signed({2'b00, r_out_col}) - $signed(SC_W'(r_p)) + $signed(SC_W'(r_dc));
        if (ec < 0) begin
            cc = '0;
        end else if (ec > w_last) begin
            cc = CW'(unsigned'(w_last));
        end else begin
            cc = CW'(unsigned'(ec));
        end
        tmp_rd = (ADDR_W+1)'(r_rbase) + (ADDR_W+1)'(cc);
        if (tmp_rd >= (ADDR_W+1)'(DEPTH)) begin
            tmp_rd = tmp_rd - (ADDR_W+1)'(DEPTH);
        end
        ls_raddr = tmp_rd[ADDR_W-1:0];
    end

    assign two_p    = DC_W'({r_p, 1'b0});
    assign wb_we    = r_rd_vld && (r_state == S_LOAD || r_state == S_LOAD_END);
    assign pass_hit = ((wb_rdata ^ r_prefix) & (8'hFF << r_bit)) == '0;
    assign cnt_now  = r_cnt;
    assign div_sh   = (SUM_W+1)'(r_wcnt) << r_bit;
    assign out_free = !r_out_vld || o_res.ready;

    wrmf_ram #(.DEPTH(DEPTH), .DW(PW)) u_line_store (
        .i_clk   (i_clk),
        .i_we    (ls_we),
        .i_waddr (r_wr_ptr),
        .i_wdata (sample),
        .i_re    (r_state == S_LOAD),
        .i_raddr (ls_raddr),
        .o_rdata (ls_rdata)
    );

    wrmf_ram #(.DEPTH(NWIN), .DW(PW)) u_window_buf (
        .i_clk   (i_clk),
        .i_we    (wb_we),
        .i_waddr (BUF_AW'(r_wcnt)),
        .i_wdata (ls_rdata),
        .i_re    (r_state == S_PASS),
        .i_raddr (BUF_AW'(r_ridx)),
        .o_rdata (wb_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_dirty    <= 1'b1;
            r_items    <= '0;
            r_out_row  <= '0;
            r_out_col  <= '0;
            r_wr_ptr   <= '0;
            r_row_base <= '0;
            r_rd_vld   <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_dirty  <= i_cfg.wr;
            r_w      <= n_w;
            r_h      <= n_h;
            r_p      <= n_p;
            r_total  <= TOT_W'(n_w) * TOT_W'(n_h);
            r_lag    <= LAG_W'(n_p) * LAG_W'(n_w) + LAG_W'(n_p);
            r_rd_vld <= (r_state == S_LOAD) || (r_state == S_PASS);

            if (o_res.ready) begin
                r_out_vld <= 1'b0;
            end

            // gather side: fold arriving window values
            if (wb_we) begin
                r_wcnt <= r_wcnt + NCNT_W'(1);
                r_sum  <= r_sum + SUM_W'(ls_rdata);
                if (ls_rdata > r_max) r_max <= ls_rdata;
                if (ls_rdata < r_min) r_min <= ls_rdata;
            end
            if (r_rd_vld && r_state == S_PASS && pass_hit) begin
                r_cnt <= r_cnt + NCNT_W'(1);
            end

            unique case (r_state)
                S_IDLE: begin
                    if (accept && (!in_frame || is_pix)) begin
                        if (in_frame) begin
                            r_wr_ptr <= (r_wr_ptr == ADDR_W'(DEPTH - 1)) ?
                                        '0 : r_wr_ptr + ADDR_W'(1);
                        end
                        r_items <= r_items + wrmf_pkg::ITEMS_W'(1);
                        if (32'(r_items) >= 32'(r_lag)) begin
                            r_last  <= (r_out_row >= RW'(r_h - EH'(1))) &&
                                       (r_out_col >= CW'(r_w - EW'(1)));
                            r_rbase <= r_row_base;
                            r_back  <= (r_out_row < RW'(r_p)) ?
                                       wrmf_pkg::P_W'(r_out_row) : r_p;
                            r_er    <= $signed({2'b00, r_out_row}) - $signed(SR_W'(r_p));
                            r_dr    <= '0;
                            r_dc    <= '0;
                            r_wcnt  <= '0;
                            r_sum   <= '0;
                            r_min   <= '1;
                            r_max   <= '0;
                            r_state <= S_BACK;
                        end
                    end
                end
                S_BACK: begin
                    if (r_back == '0) begin
                        r_state <= S_LOAD;
                    end else begin
                        r_rbase <= rb_sub;
                        r_back  <= r_back - wrmf_pkg::P_W'(1);
                    end
                end
                S_LOAD: begin
                    if (r_dc == two_p) begin
                        r_dc <= '0;
                        if (r_er >= 0 && r_er < h_last) begin
                            r_rbase <= rb_add;
                        end
                        r_er <= r_er + SR_W'(1);
                        r_dr <= r_dr + DC_W'(1);
                        if (r_dr == two_p) begin
                            r_state <= S_LOAD_END;
                        end
                    end else begin
                        r_dc <= r_dc + DC_W'(1);
                    end
                end
                S_LOAD_END: begin
                    if (!r_rd_vld) begin
                        unique case (i_cfg.filter_mode)
                            wrmf_pkg::MODE_MAX: begin
                                r_res   <= r_max;
                                r_state <= S_DONE;
                            end
                            wrmf_pkg::MODE_MIN: begin
                                r_res   <= r_min;
                                r_state <= S_DONE;
                            end
                            wrmf_pkg::MODE_MEAN: begin
                                r_rem   <= r_sum;
                                r_quo   <= '0;
                                r_bit   <= 3'd7;
                                r_state <= S_DIV;
                            end
                            default: begin
                                r_prefix <= '0;
                                r_bit    <= 3'd7;
                                r_target <= r_wcnt >> 1;
                                r_cnt    <= '0;
                                r_ridx   <= '0;
                                r_state  <= S_PASS;
                            end
                        endcase
                    end
                end
                S_PASS: begin
                    r_ridx <= r_ridx + NCNT_W'(1);
                    if (r_ridx == r_wcnt - NCNT_W'(1)) begin
                        r_state <= S_PASS_END;
                    end
                end
                S_PASS_END: begin
                    if (r_rd_vld) begin
                        if (pass_hit) r_cnt <= r_cnt + NCNT_W'(1);
                    end else begin
                        if (!(cnt_now > r_target)) begin
                            r_target <= r_target - cnt_now;
                            r_prefix[r_bit] <= 1'b1;
                        end
                        if (r_bit == '0) begin
                            r_res   <= (cnt_now > r_target) ? r_prefix : (r_prefix | 8'd1);
                            r_state <= S_DONE;
                        end else begin
                            r_bit   <= r_bit - 3'd1;
                            r_cnt   <= '0;
                            r_ridx  <= '0;
                            r_state <= S_PASS;
                        end
                    end
                end
                S_DIV: begin
                    if ((SUM_W+1)'(r_rem) >= div_sh) begin
                        r_rem        <= r_rem - SUM_W'(div_sh);
                        r_quo[r_bit] <= 1'b1;
                    end
                    if (r_bit == '0) begin
                        r_res   <= ((SUM_W+1)'(r_rem) >= div_sh) ? (r_quo | 8'd1) : r_quo;
                        r_state <= S_DONE;
                    end else begin
                        r_bit <= r_bit - 3'd1;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out_vld       <= 1'b1;
                        r_out.filtered  <= r_res;
                        r_out.frame_end <= r_last;
                        r_state         <= S_IDLE;
                        if (r_last) begin
                            r_items    <= '0;
                            r_out_row  <= '0;
                            r_out_col  <= '0;
                            r_wr_ptr   <= '0;
                            r_row_base <= '0;
                        end else if (EW'(r_out_col) + EW'(1) >= r_w) begin
                            r_out_col  <= '0;
                            r_out_row  <= r_out_row + RW'(1);
                            r_row_base <= base_add;
                        end else begin
                            r_out_col <= r_out_col + CW'(1);
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase

            if (i_cfg.wr) begin
                r_items    <= '0;
                r_out_row  <= '0;
                r_out_col  <= '0;
                r_wr_ptr   <= '0;
                r_row_base <= '0;
            end
        end
    end

    assign o_res.valid   = r_out_vld;
    assign o_res.payload = r_out;
endmodule

`default_nettype wire

// ===== design/window_rank_mean_filter.sv =====
// top level of the window rank / mean filter
// depends on wrmf_pkg, wrmf_stream_if, wrmf_apb_regs, wrmf_engine
//
// pixels enter on i_pix in raster order, one transaction per item; action 0 is
// a pixel, action 1 a drain item sent after the last pixel to flush pending
// outputs. results leave on o_res, filtered value plus a frame_end flag on
// the last output of the frame. output n follows input n + pad*width + pad.
// registers must be written over the apb port only while the block is idle;
// the block itself does not enforce this. any write to one of the five
// registers restarts the frame, and i_pix.ready drops for one cycle after it.
// an item that produces a result occupies the block while it steps back up to
// pad rows and gathers the window through the single line store read port;
// median mode then has the shared counter make eight radix passes over the
// window buffer, the mean runs eight divide steps, and maximum and minimum
// need neither. ready stays low while an item is worked on.
// a finished result sits in the output register; the next item is taken
// while it waits, and a stalled receiver holds the following result until
// the register frees. reset clears the frame counters and the output valid.
`default_nettype none

module window_rank_mean_filter #(
    parameter int MAX_WIDTH  = wrmf_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = wrmf_pkg::DEF_MAX_HEIGHT,
    parameter int MAX_WINDOW = wrmf_pkg::DEF_MAX_WINDOW
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    wrmf_stream_if.sink                      i_pix,
    wrmf_stream_if.source                    o_res,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [wrmf_pkg::APB_AW-1:0] paddr,
    input  wire logic [wrmf_pkg::APB_DW-1:0] pwdata,
    output logic      [wrmf_pkg::APB_DW-1:0] prdata,
    output logic                             pready
);
    wrmf_pkg::t_cfg cfg;

    wrmf_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    wrmf_engine #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .MAX_WINDOW (MAX_WINDOW)
    ) u_engine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_pix   (i_pix),
        .o_res   (o_res)
    );
endmodule

`default_nettype wire

// ===== design/wrmf_checker.sv =====
// port level checks of the window rank / mean filter and their bind
// depends on wrmf_pkg and window_rank_mean_filter_macros.svh
`default_nettype none
`include "window_rank_mean_filter_macros.svh"

module wrmf_checker (
    input wire logic                        i_clk,
    input wire logic                        i_rst_n,
    input wire logic                        i_in_ready,
    input wire logic                        i_out_valid,
    input wire logic                        i_out_ready,
    input wire wrmf_pkg::t_out_item         i_out_data,
    input wire logic                        i_psel,
    input wire logic                        i_penable,
    input wire logic                        i_pwrite
);
    `WRMF_CHECK(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid, "result dropped while stalled")
    `WRMF_CHECK(a_out_stable, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> $stable(i_out_data), "result changed while stalled")
    `WRMF_CHECK(a_cfg_settle, i_clk, i_rst_n, i_psel && i_penable && i_pwrite |=> !i_in_ready, "input taken during config settle")
    `WRMF_CHECK_ALWAYS(a_rst_out, i_clk, !i_rst_n |=> !i_out_valid, "result valid after reset")
endmodule

bind window_rank_mean_filter wrmf_checker u_wrmf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_pix.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_out_data  (o_res.payload),
    .i_psel      (psel),
    .i_penable   (penable),
    .i_pwrite    (pwrite)
);

`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// testbench for window_rank_mean_filter: apb register setup, raster frames with drains,
// results predicted in-bench and checked in order; depends on wrmf_pkg and wrmf_stream_if
module tb;
    localparam int STORE_DEPTH = wrmf_pkg::DEF_MAX_WINDOW * wrmf_pkg::DEF_MAX_WIDTH;
    localparam int CYCLE_LIMIT = 3000000;

    logic i_clk;
    logic i_rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [wrmf_pkg::APB_AW-1:0] paddr;
    logic [wrmf_pkg::APB_DW-1:0] pwdata;
    logic [wrmf_pkg::APB_DW-1:0] prdata;
    logic pready;
    logic rx_ready = 1'b0;

    wrmf_stream_if #(.t_payload(wrmf_pkg::t_in_item))  pix_if ();
    wrmf_stream_if #(.t_payload(wrmf_pkg::t_out_item)) res_if ();

    assign res_if.ready = rx_ready;

    window_rank_mean_filter u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix_if.sink),
        .o_res   (res_if.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // filter state mirror
    logic [wrmf_pkg::PIX_W-1:0] pix_store [STORE_DEPTH];
    int unsigned taken;
    int unsigned out_row;
    int unsigned out_col;
    int unsigned cfg_width;
    int unsigned cfg_height;
    int unsigned cfg_wsize;
    logic [wrmf_pkg::MODE_W-1:0] cfg_mode;
    logic [wrmf_pkg::PLANE_W-1:0] cfg_plane;

    wrmf_pkg::t_out_item pending_pixels[$];
    int errors;
    int sent_items;
    int cycles;
    bit quiet;
    int long_hold;
    int rx_burst;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // receiver stalls
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rx_ready <= 1'b0;
        end else if (long_hold > 0) begin
            long_hold = long_hold - 1;
            rx_ready <= 1'b0;
        end else begin
            if (!quiet && rx_burst == 0 && $urandom_range(0, 7) == 0)
                rx_burst = $urandom_range(1, 3);
            if (rx_burst > 0) begin
                rx_burst = rx_burst - 1;
                rx_ready <= 1'b0;
            end else begin
                rx_ready <= 1'b1;
            end
        end
    end

    // result checker
    always @(posedge i_clk) begin
        wrmf_pkg::t_out_item exp_px;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (pending_pixels.size() == 0) begin
                errors++;
                $display("%0t: unexpected result filtered=%0d frame_end=%0b", $time,
                         res_if.payload.filtered, res_if.payload.frame_end);
            end else begin
                exp_px = pending_pixels.pop_front();
                if (res_if.payload.filtered !== exp_px.filtered) begin
                    errors++;
                    $display("%0t: filtered expected %0d actual %0d", $time,
                             exp_px.filtered, res_if.payload.filtered);
                end
                if (res_if.payload.frame_end !== exp_px.frame_end) begin
                    errors++;
                    $display("%0t: frame_end expected %0b actual %0b", $time,
                             exp_px.frame_end, res_if.payload.frame_end);
                end
            end
        end
    end

    function automatic int unsigned eff_width();
        return (cfg_width < 1) ? 1 : (cfg_width > wrmf_pkg::DEF_MAX_WIDTH) ?
               wrmf_pkg::DEF_MAX_WIDTH : cfg_width;
    endfunction

    function automatic int unsigned eff_height();
        return (cfg_height < 1) ? 1 : (cfg_height > wrmf_pkg::DEF_MAX_HEIGHT) ?
               wrmf_pkg::DEF_MAX_HEIGHT : cfg_height;
    endfunction

    function automatic int unsigned pad_of_window();
        int unsigned p;
        case (cfg_wsize)
            3: p = 1;
            5: p = 2;
            7: p = 3;
            9: p = 4;
            default: p = 5;
        endcase
        if (p > (wrmf_pkg::DEF_MAX_WINDOW - 1) / 2) p = (wrmf_pkg::DEF_MAX_WINDOW - 1) / 2;
        return p;
    endfunction

    function automatic logic [wrmf_pkg::PIX_W-1:0] window_result(int unsigned w,
                                                                int unsigned h,
                                                                int unsigned p);
        int hist [256];
        int unsigned cnt, total, cum, hi, lo, v;
        int r, c;
        cnt = 0; total = 0; cum = 0; hi = 0; lo = 255;
        for (int i = 0; i < 256; i++) hist[i] = 0;
        for (int dr = -int'(p); dr <= int'(p); dr++) begin
            for (int dc = -int'(p); dc <= int'(p); dc++) begin
                r = int'(out_row) + dr;
                c = int'(out_col) + dc;
                if (r < 0) r = 0;
                if (r > int'(h) - 1) r = int'(h) - 1;
                if (c < 0) c = 0;
                if (c > int'(w) - 1) c = int'(w) - 1;
                v = pix_store[(r * w + c) % STORE_DEPTH];
                hist[v]++;
                total += v;
                cnt++;
                if (v > hi) hi = v;
                if (v < lo) lo = v;
            end
        end
        case (cfg_mode)
            wrmf_pkg::MODE_MAX: return hi[wrmf_pkg::PIX_W-1:0];
            wrmf_pkg::MODE_MIN: return lo[wrmf_pkg::PIX_W-1:0];
            wrmf_pkg::MODE_MEAN: return wrmf_pkg::PIX_W'(total / cnt);
            default: begin
                for (int i = 0; i < 256; i++) begin
                    cum += hist[i];
                    if (cum > cnt / 2) return wrmf_pkg::PIX_W'(i);
                end
                return 8'd255;
            end
        endcase
    endfunction

    function automatic void filter_step(input wrmf_pkg::t_in_item it);
        int unsigned w, h, p, m;
        bit last;
        wrmf_pkg::t_out_item r;
        logic [wrmf_pkg::PIX_W-1:0] s;
        w = eff_width();
        h = eff_height();
        p = pad_of_window();
        if (taken < w * h) begin
            if (it.action != wrmf_pkg::ACT_PIXEL) return;
            s = (cfg_plane == wrmf_pkg::PLANE_B) ? it.chan_b :
                (cfg_plane == wrmf_pkg::PLANE_C) ? it.chan_c : it.chan_a;
            pix_store[taken % STORE_DEPTH] = s;
        end
        m = taken;
        taken = (taken + 1) & 32'h1F_FFFF;
        if (m < p * w + p) return;
        last = (out_row >= h - 1) && (out_col >= w - 1);
        r.filtered = window_result(w, h, p);
        r.frame_end = last;
        pending_pixels.insert(pending_pixels.size(), r);
        if (last) begin
            taken = 0; out_row = 0; out_col = 0;
        end else if (out_col + 1 >= w) begin
            out_col = 0;
            out_row++;
        end else begin
            out_col++;
        end
    endfunction

    task automatic send_item(input wrmf_pkg::t_in_item it);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            pix_if.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        pix_if.valid <= 1'b1;
        pix_if.payload <= it;
        do @(posedge i_clk); while (!pix_if.ready);
        filter_step(it);
        sent_items++;
    endtask

    task automatic wait_drained();
        while (pending_pixels.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [wrmf_pkg::REGI_W-1:0] idx, input int unsigned val);
        pix_if.valid <= 1'b0;
        wait_drained();
        repeat (30) @(posedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= wrmf_pkg::APB_AW'(idx * 4);
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            wrmf_pkg::REG_IMAGE_WIDTH: cfg_width = val & 32'h7FF;
            wrmf_pkg::REG_IMAGE_HEIGHT: cfg_height = val & 32'h7FF;
            wrmf_pkg::REG_WINDOW_SIZE: cfg_wsize = val & 32'hF;
            wrmf_pkg::REG_FILTER_MODE: cfg_mode = val[wrmf_pkg::MODE_W-1:0];
            default: cfg_plane = val[wrmf_pkg::PLANE_W-1:0];
        endcase
        taken = 0; out_row = 0; out_col = 0;
    endtask

    task automatic setup(input int unsigned w, h, wsize, mode, plane);
        write_reg(wrmf_pkg::REG_IMAGE_WIDTH, w);
        write_reg(wrmf_pkg::REG_IMAGE_HEIGHT, h);
        write_reg(wrmf_pkg::REG_WINDOW_SIZE, wsize);
        write_reg(wrmf_pkg::REG_FILTER_MODE, mode);
        write_reg(wrmf_pkg::REG_PLANE_SELECT, plane);
    endtask

    function automatic logic [wrmf_pkg::PIX_W-1:0] rand_sample();
        case ($urandom_range(0, 5))
            0: return 8'd0;
            1: return 8'd255;
            default: return wrmf_pkg::PIX_W'($urandom);
        endcase
    endfunction

    task automatic send_pixel(input logic action);
        wrmf_pkg::t_in_item it;
        it.action = action;
        it.chan_a = rand_sample();
        it.chan_b = rand_sample();
        it.chan_c = rand_sample();
        send_item(it);
    endtask

    // full frame plus the drains that flush it; noise adds early drains and surplus pixels
    task automatic run_frame(input bit noise);
        int unsigned npix, lag;
        npix = eff_width() * eff_height();
        lag = pad_of_window() * eff_width() + pad_of_window();
        for (int unsigned i = 0; i < npix; i++) begin
            if (noise && $urandom_range(0, 9) == 0) send_pixel(~wrmf_pkg::ACT_PIXEL);
            send_pixel(wrmf_pkg::ACT_PIXEL);
        end
        for (int unsigned j = 0; j < lag; j++)
            send_pixel((noise && $urandom_range(0, 3) == 0) ? wrmf_pkg::ACT_PIXEL
                                                             : ~wrmf_pkg::ACT_PIXEL);
    endtask

    task automatic test_directed();
        wrmf_pkg::t_in_item it;
        setup(2, 2, 3, wrmf_pkg::MODE_MEDIAN, 0);
        it = '{action: ~wrmf_pkg::ACT_PIXEL, chan_a: 8'd0, chan_b: 8'd0, chan_c: 8'd0};
        send_item(it);
        it = '{action: wrmf_pkg::ACT_PIXEL, chan_a: 8'd0, chan_b: 8'd255, chan_c: 8'd255};
        send_item(it);
        it = '{action: wrmf_pkg::ACT_PIXEL, chan_a: 8'd255, chan_b: 8'd0, chan_c: 8'd0};
        send_item(it);
        it = '{action: wrmf_pkg::ACT_PIXEL, chan_a: 8'd255, chan_b: 8'd255, chan_c: 8'd0};
        send_item(it);
        it = '{action: wrmf_pkg::ACT_PIXEL, chan_a: 8'd1, chan_b: 8'd128, chan_c: 8'd255};
        send_item(it);
        it.chan_a = 8'd77;
        send_item(it);
        it.action = ~wrmf_pkg::ACT_PIXEL;
        send_item(it);
        send_item(it);
        // zero sizes clamp to one, unlisted window acts as eleven
        setup(0, 0, 15, wrmf_pkg::MODE_MAX, 1);
        run_frame(0);
    endtask

    task automatic test_size_extremes();
        setup(1024, 1024, 11, wrmf_pkg::MODE_MIN, 3);
        repeat (3) send_pixel(wrmf_pkg::ACT_PIXEL);
        setup(2047, 2047, 9, wrmf_pkg::MODE_MEAN, 2);
        repeat (2) send_pixel(wrmf_pkg::ACT_PIXEL);
        setup(1, 3, 11, wrmf_pkg::MODE_MEAN, 0);
        run_frame(0);
    endtask

    task automatic test_backpressure();
        setup(4, 3, 3, wrmf_pkg::MODE_MIN, 2);
        @(posedge i_clk);
        long_hold = 600;
        run_frame(0);
    endtask

    task automatic test_sender_pause();
        setup(3, 3, 5, wrmf_pkg::MODE_MEAN, 3);
        run_frame(1);
        wait_drained();
        run_frame(0);
    endtask

    task automatic test_random_frames();
        int unsigned sizes [7] = '{3, 5, 7, 9, 11, 0, 15};
        while (sent_items < 520) begin
            setup($urandom_range(1, 6), $urandom_range(1, 5), sizes[$urandom_range(0, 6)],
                  $urandom_range(0, 3), $urandom_range(0, 3));
            if ($urandom_range(0, 7) == 0)
                repeat ($urandom_range(1, eff_width() * eff_height()))
                    send_pixel(wrmf_pkg::ACT_PIXEL);
            else
                run_frame($urandom_range(0, 1));
        end
    endtask

    task automatic test_quiet_tail();
        quiet = 1;
        setup(5, 2, 3, wrmf_pkg::MODE_MEDIAN, 1);
        run_frame(0);
        setup(3, 4, 7, wrmf_pkg::MODE_MAX, 2);
        run_frame(0);
    endtask

    initial begin
        i_rst_n <= 1'b0;
        pix_if.valid <= 1'b0;
        pix_if.payload <= '0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        errors = 0; sent_items = 0; cycles = 0; quiet = 0; long_hold = 0; rx_burst = 0;
        for (int i = 0; i < STORE_DEPTH; i++) pix_store[i] = '0;
        taken = 0; out_row = 0; out_col = 0;
        cfg_width = 256; cfg_height = 256; cfg_wsize = 3;
        cfg_mode = wrmf_pkg::MODE_MEDIAN; cfg_plane = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_size_extremes();
        test_backpressure();
        test_sender_pause();
        test_random_frames();
        test_quiet_tail();

        pix_if.valid <= 1'b0;
        wait_drained();
        repeat (50) @(posedge i_clk);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule

// ===== filelist.f =====
+incdir+design
design/wrmf_pkg.sv
design/wrmf_stream_if.sv
design/wrmf_ram.sv
design/wrmf_apb_regs.sv
design/wrmf_engine.sv
design/window_rank_mean_filter.sv
design/wrmf_checker.sv
tb/tb.sv
